// ===== hdl/cbm_pkg.sv =====
// cbm_pkg: shared types and constants of the cartridge bank mapper
// no dependencies; used by the controller, datapath and top level
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int CBM_VISIBLE_LINES = 240;
    localparam int CBM_BANK_REGS     = 8;
    localparam int CBM_CNT_W         = 9;
    localparam int CBM_CFG_IDX_W     = 1;

    // item kinds
    typedef enum logic [1:0] {
        OP_REG_WRITE = 2'd0,
        OP_TICK      = 2'd1,
        OP_CPU_XLATE = 2'd2,
        OP_PPU_XLATE = 2'd3
    } cbm_op_t;

    // configuration register indexes
    localparam logic [CBM_CFG_IDX_W-1:0] CFG_PRG_COUNT = 1'b0;
    localparam logic [CBM_CFG_IDX_W-1:0] CFG_CHR_COUNT = 1'b1;

    // cpu register decode
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

    localparam logic [CBM_CNT_W-1:0] CBM_PRG_COUNT_RST = 9'd2;
    localparam logic [CBM_CNT_W-1:0] CBM_CHR_COUNT_RST = 9'd8;
    localparam logic [CBM_CNT_W-1:0] CBM_COUNT_MAX     = 9'd256;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } cbm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic needs_div;
        logic div_last;
        logic out_free;
    } cbm_stat_t;

endpackage

// ===== hdl/cbm_in_if.sv =====
// cbm_in_if: request channel carrying one mapper item
// no dependencies
`timescale 1ns / 1ps

interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scan_line;

    modport source (output valid, output opcode, output address, output data,
                    output scan_line, input ready);
    modport sink (input valid, input opcode, input address, input data,
                  input scan_line, output ready);
endinterface

// ===== hdl/cbm_out_if.sv =====
// cbm_out_if: result channel carrying one mapper result
// no dependencies
`timescale 1ns / 1ps

interface cbm_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] prg_rom_address;
    logic [17:0] chr_address;
    logic        map_valid;
    logic        mirror_horizontal;
    logic        irq_line;

    modport source (output valid, output prg_rom_address, output chr_address,
                    output map_valid, output mirror_horizontal, output irq_line,
                    input ready);
    modport sink (input valid, input prg_rom_address, input chr_address,
                  input map_valid, input mirror_horizontal, input irq_line,
                  output ready);
endinterface

// ===== hdl/cartridge_bank_mapper_scanline_irq.sv =====
// cartridge bank mapper with scanline irq counter: top level
// one request at a time: a new request is taken only when idle, after the last one commits;
// translations pass through the bank remainder unit, which resolves two bits of the 8-bit
// bank number per cycle
// a finished result waits in the output register while the next request is taken
// reset (rst_n, async low) clears all mapper state, counts go to 2 prg and 8 chr banks
`timescale 1ns / 1ps

module cartridge_bank_mapper_scanline_irq #(
    parameter int VISIBLE_LINES = cbm_pkg::CBM_VISIBLE_LINES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cbm_in_if.sink                            in_ch,
    cbm_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [cbm_pkg::CBM_CFG_IDX_W-1:0] cfg_index,
    input  logic [cbm_pkg::CBM_CNT_W-1:0]     cfg_data
);
    import cbm_pkg::*;

    cbm_cmd_t  cmd;
    cbm_stat_t stat;

    cbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cbm_datapath #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== hdl/cbm_ctrl.sv =====
// cbm_ctrl: sequencer for one mapper request (load, remainder steps, commit)
// depends on cbm_pkg
`timescale 1ns / 1ps

module cbm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cbm_pkg::cbm_stat_t stat,
    output cbm_pkg::cbm_cmd_t  cmd
);
    import cbm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.load     = (state_reg == S_IDLE) && in_valid;
    assign cmd.div_step = (state_reg == S_DIV) && stat.needs_div;
    assign cmd.commit   = (state_reg == S_FIN) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!stat.needs_div || stat.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hdl/cbm_datapath.sv =====
// cbm_datapath: mapper state, bank remainder unit (two bits per cycle) and result register
// depends on cbm_pkg, cbm_in_if, cbm_out_if
`timescale 1ns / 1ps

module cbm_datapath #(
    parameter int VISIBLE_LINES = cbm_pkg::CBM_VISIBLE_LINES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    cbm_in_if.sink                              in_ch,
    cbm_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [cbm_pkg::CBM_CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbm_pkg::CBM_CNT_W-1:0]       cfg_data,
    input  cbm_pkg::cbm_cmd_t                   cmd,
    output cbm_pkg::cbm_stat_t                  stat
);
    import cbm_pkg::*;

    localparam int LINE_CMP_W = $clog2(VISIBLE_LINES + 1) > 9 ? $clog2(VISIBLE_LINES + 1) : 10;
    localparam logic [LINE_CMP_W-1:0] VIS_LIMIT = LINE_CMP_W'(VISIBLE_LINES);

    // configuration
    logic [CBM_CNT_W-1:0] prg_count_reg;
    logic [CBM_CNT_W-1:0] chr_count_reg;

    // mapper state
    logic [4:0] bank_select_reg;
    logic [7:0] bank_regs_reg [CBM_BANK_REGS];
    logic       mirror_reg;
    logic [7:0] irq_reload_reg;
    logic [7:0] irq_count_reg;
    logic       reload_pending_reg;
    logic       irq_enable_reg;
    logic       irq_pending_reg;

    // latched request
    cbm_op_t              op_reg;
    logic [15:0]          addr_reg;
    logic [7:0]           data_reg;
    logic [8:0]           line_reg;
    logic [CBM_CNT_W-1:0] count_reg;
    logic [7:0]           dividend_reg;
    logic [CBM_CNT_W-1:0] rem_reg;
    logic [1:0]           step_reg;

    // result register
    logic        out_valid_reg;
    logic [20:0] prg_out_reg;
    logic [17:0] chr_out_reg;
    logic        map_valid_reg;
    logic        mirror_out_reg;
    logic        irq_out_reg;

    // load-time selection
    cbm_op_t              in_op;
    logic [2:0]           slot;
    logic [2:0]           rd_idx;
    logic [7:0]           rd_bank;
    logic [CBM_CNT_W-1:0] raw_count;
    logic [CBM_CNT_W-1:0] count_clamped;
    logic [7:0]           dividend_in;

    assign in_op = cbm_op_t'(in_ch.opcode);
    assign slot  = in_ch.address[12:10] ^ {bank_select_reg[4], 2'b00};

    always_comb
    begin
        if (in_op == OP_CPU_XLATE)
            rd_idx = {2'b11, (in_ch.address[14:13] == 2'd1)};
        else if (!slot[2])
            rd_idx = {2'b00, slot[1]};
        else
            rd_idx = slot - 3'd2;
    end

    assign rd_bank = bank_regs_reg[rd_idx];
    // 2 KiB pairs ignore the low bit of the register
    assign dividend_in = (in_op != OP_CPU_XLATE && !slot[2]) ? {rd_bank[7:1], slot[0]} : rd_bank;
    assign raw_count   = (in_op == OP_CPU_XLATE) ? prg_count_reg : chr_count_reg;
    assign count_clamped = raw_count[8] ? CBM_COUNT_MAX : raw_count;

    // remainder: two restoring steps per cycle
    logic [CBM_CNT_W:0] r1;
    logic [CBM_CNT_W:0] r1_fix;
    logic [CBM_CNT_W:0] r2;
    logic [CBM_CNT_W:0] r2_fix;

    always_comb
    begin
        r1     = {rem_reg, dividend_reg[7]};
        r1_fix = (r1 >= {1'b0, count_reg}) ? r1 - {1'b0, count_reg} : r1;
        r2     = {r1_fix[CBM_CNT_W-1:0], dividend_reg[6]};
        r2_fix = (r2 >= {1'b0, count_reg}) ? r2 - {1'b0, count_reg} : r2;
    end

    assign stat.needs_div = op_reg[1];
    assign stat.div_last  = (step_reg == 2'd3);
    assign stat.out_free  = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_op;
            addr_reg     <= in_ch.address;
            data_reg     <= in_ch.data;
            line_reg     <= in_ch.scan_line;
            count_reg    <= count_clamped;
            dividend_reg <= dividend_in;
            rem_reg      <= '0;
            step_reg     <= 2'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg      <= r2_fix[CBM_CNT_W-1:0];
            dividend_reg <= {dividend_reg[5:0], 2'b00};
            step_reg     <= step_reg + 2'd1;
        end
    end

    // translation results
    logic [7:0]  bank_mod;
    logic [7:0]  last_bank;
    logic [7:0]  second_bank;
    logic [7:0]  prg_bank;
    logic        prg_ok;
    logic        chr_ok;
    logic        mode;

    assign bank_mod    = rem_reg[7:0];
    assign last_bank   = 8'(count_reg - 9'd1);
    assign second_bank = (count_reg >= 9'd2) ? 8'(count_reg - 9'd2) : last_bank;
    assign mode        = bank_select_reg[3];
    assign prg_ok      = (count_reg != '0) && addr_reg[15];
    assign chr_ok      = (count_reg != '0);

    always_comb
    begin
        case (addr_reg[14:13])
            2'd0:    prg_bank = mode ? second_bank : bank_mod;
            2'd1:    prg_bank = bank_mod;
            2'd2:    prg_bank = mode ? bank_mod : second_bank;
            default: prg_bank = last_bank;
        endcase
    end

    // state update for the committed request
    logic [4:0]  bank_select_next;
    logic        mirror_next;
    logic [7:0]  irq_reload_next;
    logic [7:0]  irq_count_next;
    logic        reload_pending_next;
    logic        irq_enable_next;
    logic        irq_pending_next;
    logic        bank_we;
    logic [15:0] decoded;

    assign decoded = addr_reg & REG_DECODE_MASK;
    assign bank_we = (op_reg == OP_REG_WRITE) && (decoded == REG_BANK_DATA);

    always_comb
    begin
        bank_select_next    = bank_select_reg;
        mirror_next         = mirror_reg;
        irq_reload_next     = irq_reload_reg;
        irq_count_next      = irq_count_reg;
        reload_pending_next = reload_pending_reg;
        irq_enable_next     = irq_enable_reg;
        irq_pending_next    = irq_pending_reg;
        case (op_reg)
            OP_REG_WRITE:
            begin
                case (decoded)
                    REG_BANK_SELECT: bank_select_next = {data_reg[7], data_reg[6], data_reg[2:0]};
                    REG_MIRROR:      mirror_next = data_reg[0];
                    REG_IRQ_LATCH:   irq_reload_next = data_reg;
                    REG_IRQ_RELOAD:
                    begin
                        irq_count_next      = 8'd0;
                        reload_pending_next = 1'b1;
                    end
                    REG_IRQ_DISABLE:
                    begin
                        irq_enable_next  = 1'b0;
                        irq_pending_next = 1'b0;
                    end
                    REG_IRQ_ENABLE:  irq_enable_next = 1'b1;
                    default:         ;
                endcase
            end
            OP_TICK:
            begin
                if (LINE_CMP_W'(line_reg) < VIS_LIMIT)
                begin
                    if (irq_count_reg == 8'd0 || reload_pending_reg)
                    begin
                        irq_count_next      = irq_reload_reg;
                        reload_pending_next = 1'b0;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg - 8'd1;
                    end
                    if (irq_count_next == 8'd0 && irq_enable_reg)
                        irq_pending_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg      <= CBM_PRG_COUNT_RST;
            chr_count_reg      <= CBM_CHR_COUNT_RST;
            bank_select_reg    <= '0;
            for (int i = 0; i < CBM_BANK_REGS; i++)
                bank_regs_reg[i] <= '0;
            mirror_reg         <= 1'b0;
            irq_reload_reg     <= '0;
            irq_count_reg      <= '0;
            reload_pending_reg <= 1'b0;
            irq_enable_reg     <= 1'b0;
            irq_pending_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PRG_COUNT)
                    prg_count_reg <= cfg_data;
                else if (cfg_index == CFG_CHR_COUNT)
                    chr_count_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                bank_select_reg    <= bank_select_next;
                mirror_reg         <= mirror_next;
                irq_reload_reg     <= irq_reload_next;
                irq_count_reg      <= irq_count_next;
                reload_pending_reg <= reload_pending_next;
                irq_enable_reg     <= irq_enable_next;
                irq_pending_reg    <= irq_pending_next;
                if (bank_we)
                    bank_regs_reg[bank_select_reg[2:0]] <= data_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            prg_out_reg    <= (op_reg == OP_CPU_XLATE && prg_ok) ? {prg_bank, addr_reg[12:0]} : '0;
            chr_out_reg    <= (op_reg == OP_PPU_XLATE && chr_ok) ? {bank_mod, addr_reg[9:0]} : '0;
            map_valid_reg  <= (op_reg == OP_CPU_XLATE && prg_ok) ||
                              (op_reg == OP_PPU_XLATE && chr_ok);
            mirror_out_reg <= mirror_next;
            irq_out_reg    <= irq_pending_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.prg_rom_address   = prg_out_reg;
    assign out_ch.chr_address       = chr_out_reg;
    assign out_ch.map_valid         = map_valid_reg;
    assign out_ch.mirror_horizontal = mirror_out_reg;
    assign out_ch.irq_line          = irq_out_reg;

endmodule
